### rtl/core/bmc_pkg.sv
// ----------------------------------------------------------------------------
// bmc_pkg
// Shared types and constants of the bracket match checker.
// ----------------------------------------------------------------------------
package bmc_pkg;

	typedef enum logic [1:0] {
		K_OPEN,
		K_CLOSE,
		K_OTHER
	} kind_t;

	typedef enum logic [2:0] {
		ST_COMPLETE   = 3'd0,
		ST_CORRUPT    = 3'd1,
		ST_COMPLETION = 3'd2,
		ST_INVALID    = 3'd3,
		ST_OVERFLOW   = 3'd4
	} status_t;

	// classified item handed from front to back
	typedef struct packed {
		kind_t       kind;
		logic [1:0]  code;   // closer code: 0 ')', 1 ']', 2 '}', 3 '>'
		logic [7:0]  symbol;
		logic        eol;
	} cmd_t;

	localparam int unsigned CMD_W = $bits(cmd_t);

	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_LANGLE = 8'h3C;
	localparam logic [7:0] CH_RANGLE = 8'h3E;

	function automatic logic [7:0] closer_char(input logic [1:0] code);
		logic [7:0] c;
		unique case (code)
			2'd0: c = CH_RPAREN;
			2'd1: c = CH_RBRACK;
			2'd2: c = CH_RBRACE;
			2'd3: c = CH_RANGLE;
		endcase
		return c;
	endfunction

endpackage

### rtl/core/bmc_front.sv
// ----------------------------------------------------------------------------
// bmc_front
// Accepts characters, classifies them and tracks the position in the line.
// ----------------------------------------------------------------------------
module bmc_front #(
	parameter int unsigned POSITION_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [7:0]                s_tdata,   // symbol
	input  logic                      s_tlast,   // end_of_line
	input  logic                      q_full,
	output logic                      q_push,
	output bmc_pkg::cmd_t             q_cmd,
	output logic [POSITION_BITS-1:0]  q_pos
);
	import bmc_pkg::*;

	logic [POSITION_BITS-1:0] char_index_q;

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && s_tready;
	assign q_pos    = char_index_q;

	always_comb begin
		q_cmd.symbol = s_tdata;
		q_cmd.eol    = s_tlast;
		q_cmd.kind   = K_OTHER;
		q_cmd.code   = 2'd0;
		unique case (s_tdata)
			CH_LPAREN: begin q_cmd.kind = K_OPEN;  q_cmd.code = 2'd0; end
			CH_LBRACK: begin q_cmd.kind = K_OPEN;  q_cmd.code = 2'd1; end
			CH_LBRACE: begin q_cmd.kind = K_OPEN;  q_cmd.code = 2'd2; end
			CH_LANGLE: begin q_cmd.kind = K_OPEN;  q_cmd.code = 2'd3; end
			CH_RPAREN: begin q_cmd.kind = K_CLOSE; q_cmd.code = 2'd0; end
			CH_RBRACK: begin q_cmd.kind = K_CLOSE; q_cmd.code = 2'd1; end
			CH_RBRACE: begin q_cmd.kind = K_CLOSE; q_cmd.code = 2'd2; end
			CH_RANGLE: begin q_cmd.kind = K_CLOSE; q_cmd.code = 2'd3; end
			default: ;
		endcase
	end

	// position saturates at all ones
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_index_q <= '0;
		end else if (q_push) begin
			if (s_tlast) begin
				char_index_q <= '0;
			end else if (char_index_q != '1) begin
				char_index_q <= char_index_q + POSITION_BITS'(1);
			end
		end
	end

endmodule

### rtl/core/bmc_queue.sv
// ----------------------------------------------------------------------------
// bmc_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module bmc_queue #(
	parameter int unsigned WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	output logic             valid,
	output logic [WIDTH-1:0] data,
	input  logic             pop
);
	logic [WIDTH-1:0] entry_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign full  = (count_q == 2'd2);
	assign valid = (count_q != 2'd0);
	assign data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)      count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

endmodule

### rtl/core/bmc_back.sv
// ----------------------------------------------------------------------------
// bmc_back
// Closer stack, line state and result register; drains completion runs.
// ----------------------------------------------------------------------------
module bmc_back #(
	parameter int unsigned STACK_DEPTH   = 64,
	parameter int unsigned POSITION_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_valid,
	input  bmc_pkg::cmd_t             q_cmd,
	input  logic [POSITION_BITS-1:0]  q_pos,
	output logic                      q_pop,
	output logic                      out_valid,
	input  logic                      out_ready,
	output bmc_pkg::status_t          out_status,
	output logic [7:0]                out_char,
	output logic [POSITION_BITS-1:0]  out_pos,
	output logic                      out_last
);
	import bmc_pkg::*;

	localparam int unsigned LW = $clog2(STACK_DEPTH + 1);
	localparam int unsigned IW = $clog2(STACK_DEPTH);

	typedef enum logic {S_RUN, S_DRAIN} state_t;

	state_t  state_q, state_d;
	logic [LW-1:0] level_q, lvl_d, lvl_m1;
	logic          failed_q, failed_d;
	logic [1:0]    stack_mem [STACK_DEPTH];
	logic [1:0]    rd_q;      // stack top for the current level
	logic [IW-1:0] raddr, waddr;
	logic          push_en;
	logic          out_free;
	logic          emit;
	status_t       e_status;
	logic [7:0]    e_char;
	logic [POSITION_BITS-1:0] e_pos;
	logic          e_last;

	assign out_free = !out_valid || out_ready;
	assign lvl_m1   = lvl_d - LW'(1);
	assign raddr    = lvl_m1[IW-1:0];
	assign waddr    = level_q[IW-1:0];

	always_comb begin
		state_d  = state_q;
		lvl_d    = level_q;
		failed_d = failed_q;
		q_pop    = 1'b0;
		push_en  = 1'b0;
		emit     = 1'b0;
		e_status = ST_COMPLETE;
		e_char   = 8'd0;
		e_pos    = '0;
		e_last   = 1'b1;
		unique case (state_q)
			S_RUN: begin
				if (q_valid && out_free) begin
					q_pop = 1'b1;
					if (!failed_q) begin
						unique case (q_cmd.kind)
							K_OPEN: begin
								if (level_q < LW'(STACK_DEPTH)) begin
									push_en = 1'b1;
									lvl_d   = level_q + LW'(1);
								end else begin
									emit     = 1'b1;
									e_status = ST_OVERFLOW;
									failed_d = 1'b1;
								end
							end
							K_CLOSE: begin
								if (level_q != '0 && rd_q == q_cmd.code) begin
									lvl_d = level_q - LW'(1);
								end else begin
									emit     = 1'b1;
									e_status = ST_CORRUPT;
									failed_d = 1'b1;
								end
							end
							default: begin
								emit     = 1'b1;
								e_status = ST_INVALID;
								failed_d = 1'b1;
							end
						endcase
						if (emit) begin
							e_char = q_cmd.symbol;
							e_pos  = q_pos;
						end
						if (q_cmd.eol && !failed_d) begin
							if (lvl_d == '0) begin
								emit     = 1'b1;
								e_status = ST_COMPLETE;
							end else begin
								state_d = S_DRAIN;
							end
						end
					end
					// line ends here unless a completion run follows
					if (q_cmd.eol && state_d == S_RUN) begin
						lvl_d    = '0;
						failed_d = 1'b0;
					end
				end
			end
			S_DRAIN: begin
				if (out_free) begin
					emit     = 1'b1;
					e_status = ST_COMPLETION;
					e_char   = closer_char(rd_q);
					e_last   = (level_q == LW'(1));
					lvl_d    = level_q - LW'(1);
					if (e_last) begin
						state_d  = S_RUN;
						failed_d = 1'b0;
					end
				end
			end
			default: ;
		endcase
	end

	// stack memory; read follows the next level, bypassing a same-cycle push
	always_ff @(posedge clk) begin
		if (push_en) begin
			stack_mem[waddr] <= q_cmd.code;
		end
		if (push_en && waddr == raddr) begin
			rd_q <= q_cmd.code;
		end else begin
			rd_q <= stack_mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_RUN;
			level_q   <= '0;
			failed_q  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			state_q  <= state_d;
			level_q  <= lvl_d;
			failed_q <= failed_d;
			if (emit) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_status <= e_status;
			out_char   <= e_char;
			out_pos    <= e_pos;
			out_last   <= e_last;
		end
	end

`ifndef SYNTHESIS
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= LW'(STACK_DEPTH))
		else $error("stack level beyond depth");

	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DRAIN |-> level_q != '0 && !failed_q)
		else $error("drain with empty stack or failed line");

	a_drain_emits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DRAIN && out_free |=>
			out_valid && out_status == ST_COMPLETION)
		else $error("drain step gave no completion item");

	a_no_pop_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DRAIN |-> !q_pop)
		else $error("queue popped during drain");
`endif

endmodule

### rtl/core/bracket_match_checker_unit.sv
// ----------------------------------------------------------------------------
// bracket_match_checker_unit
// Bracket balance checker over a character stream, one character per item.
// ----------------------------------------------------------------------------
// Input channel s_*: one character per item in s_tdata, s_tlast marks the
// last character of a line. Output channel m_*: status in m_tuser, offending
// or completion character and its position in m_tdata, m_tlast on the final
// item reported for a line.
// The front classifies each character and counts its position; a two-entry
// queue feeds the back, which owns the closer stack and the result register.
// Throughput: one character per cycle while m_tready is high and no
// completion run is draining. A clean line with open brackets left at its
// end drains a completion run, one closer per cycle while m_tready is
// high; the back pops no character meanwhile. A result is registered: the
// queue entry is written when the character is accepted, and the result
// register when the back pops that entry.
// Reset clears the line state and empties the queue; the stack memory needs
// no clearing pass, entries are only read after being written.
// When m_tready is low with a result pending, the result register holds,
// the back stops, the two-entry queue fills and s_tready drops.
// ----------------------------------------------------------------------------
module bracket_match_checker_unit #(
	parameter int unsigned STACK_DEPTH   = 64,
	parameter int unsigned POSITION_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] symbol
	input  logic       s_tlast,   // end_of_line
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [((8 + POSITION_BITS + 7) / 8) * 8 - 1:0] m_tdata,
	                              // report_char, then position, zero padded
	output logic [2:0] m_tuser,   // [2:0] status
	output logic       m_tlast    // run_last
);
	import bmc_pkg::*;

	localparam int unsigned OUT_W = ((8 + POSITION_BITS + 7) / 8) * 8;
	localparam int unsigned QW    = CMD_W + POSITION_BITS;

	logic                     q_full, q_push, q_valid, q_pop;
	cmd_t                     f_cmd, b_cmd;
	logic [POSITION_BITS-1:0] f_pos, b_pos;
	logic [QW-1:0]            q_wdata, q_rdata;
	status_t                  out_status;
	logic [7:0]               out_char;
	logic [POSITION_BITS-1:0] out_pos;

	bmc_front #(
		.POSITION_BITS(POSITION_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_cmd   (f_cmd),
		.q_pos   (f_pos)
	);

	assign q_wdata = {f_pos, f_cmd};

	bmc_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_wdata),
		.full     (q_full),
		.valid    (q_valid),
		.data     (q_rdata),
		.pop      (q_pop)
	);

	assign b_cmd = cmd_t'(q_rdata[CMD_W-1:0]);
	assign b_pos = q_rdata[CMD_W +: POSITION_BITS];

	bmc_back #(
		.STACK_DEPTH  (STACK_DEPTH),
		.POSITION_BITS(POSITION_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_cmd     (b_cmd),
		.q_pos     (b_pos),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_status(out_status),
		.out_char  (out_char),
		.out_pos   (out_pos),
		.out_last  (m_tlast)
	);

	assign m_tuser = out_status;
	assign m_tdata = OUT_W'({out_pos, out_char});

endmodule
